// ===== sv/sbda_pkg.sv =====
`default_nettype none

package sbda_pkg;

    // ascii codes, masked to the six bits of the character field
    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_MINUS = 6'd45;

    // shift-add-3 correction: a bcd digit of five or more gets three added
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    localparam int CHAR_BITS  = 6;
    localparam int OUT_TDATA  = 8;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SIGN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;        // take a new value, form its magnitude
        logic step;        // one double-dabble bit step
        logic find;        // latch the leading non-zero digit position
        logic push_sign;   // place a minus sign in the output register
        logic push_digit;  // place the current digit, move down one digit
    } t_cmd;

    typedef struct packed {
        logic conv_done;   // the step now running is the final one
        logic neg;
        logic ptr_zero;    // current digit is the least significant one
        logic slot_free;   // output register can take a character
    } t_sts;

endpackage

`default_nettype wire

// ===== sv/sbda_ctrl.sv =====
`default_nettype none

module sbda_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire sbda_pkg::t_sts i_sts,
    output sbda_pkg::t_cmd     o_cmd
);
    import sbda_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                o_cmd.find = 1'b1;
                if (!i_sts.neg) begin
                    n_state = S_EMIT;
                end else if (i_sts.slot_free) begin
                    o_cmd.push_sign = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.push_digit = 1'b1;
                    if (i_sts.ptr_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sbda_dp.sv =====
`default_nettype none

module sbda_dp #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [VALUE_BITS-1:0]   i_value,
    input  wire sbda_pkg::t_cmd          i_cmd,
    output sbda_pkg::t_sts               o_sts,
    input  wire logic                    i_out_ready,
    output logic                         o_out_valid,
    output logic [sbda_pkg::CHAR_BITS-1:0] o_char,
    output logic                         o_last
);
    import sbda_pkg::*;

    // decimal digits of the most negative value's magnitude
    localparam int NDIG     = (((VALUE_BITS - 1) * 30103) / 100000) + 1;
    localparam int BCD_BITS = NDIG * 4;
    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
    localparam int PTR_BITS = $clog2(NDIG);

    logic [VALUE_BITS-1:0] r_mag;
    logic [BCD_BITS-1:0]   r_bcd;
    logic [CNT_BITS-1:0]   r_bit_cnt;
    logic [PTR_BITS-1:0]   r_ptr;
    logic                  r_neg;
    logic                  r_out_valid;
    logic [CHAR_BITS-1:0]  r_char;
    logic                  r_last;

    logic [BCD_BITS-1:0]   adj_bcd;
    logic [PTR_BITS-1:0]   lead_ptr;
    logic [3:0]            cur_digit;
    logic                  slot_free;

    // add-3 correction on every digit, all in parallel
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*4 +: 4] >= BCD_ADJ_MIN) begin
                adj_bcd[i*4 +: 4] = r_bcd[i*4 +: 4] + BCD_ADJ;
            end else begin
                adj_bcd[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    // highest non-zero digit, zero when the whole value is zero
    always_comb begin
        lead_ptr = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*4 +: 4] != 4'd0) begin
                lead_ptr = PTR_BITS'(i);
            end
        end
    end

    assign cur_digit = r_bcd[r_ptr*4 +: 4];
    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg     <= i_value[VALUE_BITS-1];
            r_mag     <= i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
            r_bcd     <= '0;
            r_bit_cnt <= CNT_BITS'(VALUE_BITS);
        end else if (i_cmd.step) begin
            {r_bcd, r_mag} <= {adj_bcd, r_mag} << 1;
            r_bit_cnt      <= r_bit_cnt - 1'b1;
        end
        if (i_cmd.find) begin
            r_ptr <= lead_ptr;
        end else if (i_cmd.push_digit) begin
            r_ptr <= r_ptr - 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_sign || i_cmd.push_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_sign) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.push_digit) begin
            r_char <= CHAR_ZERO + {2'b00, cur_digit};
            r_last <= (r_ptr == '0);
        end
    end

    assign o_sts.conv_done = (r_bit_cnt == CNT_BITS'(1));
    assign o_sts.neg       = r_neg;
    assign o_sts.ptr_zero  = (r_ptr == '0);
    assign o_sts.slot_free = slot_free;

    assign o_out_valid = r_out_valid;
    assign o_char      = r_char;
    assign o_last      = r_last;

    a_push_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push_sign || i_cmd.push_digit) |-> slot_free)
        else $error("character pushed into an occupied output register");

    a_load_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_bcd == '0))
        else $error("bcd accumulator not cleared on load");

    a_step_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_bit_cnt != '0))
        else $error("bit step beyond the value width");

    a_sign_neg : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_sign |-> r_neg)
        else $error("minus sign for a non-negative value");

endmodule

`default_nettype wire

// ===== sv/signed_binary_to_decimal_ascii.sv =====
// signed binary to decimal ascii converter
//
// input channel s_axis: one item is one signed two's complement value of
// VALUE_BITS bits in the low bits of s_axis_tdata
// output channel m_axis: one item per character, most significant first;
// a minus sign leads negative values, leading zeros are dropped, zero gives
// a single '0', and m_axis_tlast marks the final character of each value
//
// sequence: an accepted value goes through the shift-add-3 binary to bcd
// loop (one bit per cycle), then its leading digit is located, at which
// point a negative value also loads its minus sign once the output register
// is free, then one digit per cycle goes into the output register while the
// receiver is ready. s_axis_tready rises again only once the last character
// of a value has been loaded, so a new value is not taken while the last
// one is still being converted or emitted
//
// reset (synchronous, active low) returns the controller to idle and empties
// the output register. a stalled receiver holds the current character and
// the sign and digit output waits; nothing is dropped
`default_nettype none

module signed_binary_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // value
    input  wire logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // character, then zero padding
    output logic [sbda_pkg::OUT_TDATA-1:0]              m_axis_tdata,
    output logic                                        m_axis_tlast
);
    import sbda_pkg::*;

    t_cmd                 cmd;
    t_sts                 sts;
    logic [CHAR_BITS-1:0] out_char;

    sbda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // padding bits of tdata above the value width are ignored
    sbda_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (s_axis_tdata[VALUE_BITS-1:0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_char      (out_char),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA - CHAR_BITS){1'b0}}, out_char};

endmodule

`default_nettype wire

// ===== test/tb_signed_binary_to_decimal_ascii.sv =====
`default_nettype none

module tb_signed_binary_to_decimal_ascii;

    import sbda_pkg::*;

    localparam int VALUE_BITS  = 32;
    localparam int STALL_LIMIT = 2000;   // cycles with no item moving on either side
    localparam int SETTLE      = 60;     // conversion steps + find + up to 11 characters, with margin
    localparam int RANDOM_ITEMS = 290;

    // one character of decimal text still owed by the block
    typedef struct {
        logic [CHAR_BITS-1:0] code;
        logic                 last;
        logic [31:0]          source;   // value the character belongs to, for messages
    } t_text_char;

    // one value waiting to be sent; hold set means wait for all text first
    typedef struct {
        logic [31:0] value;
        bit          hold;
    } t_value_item;

    // receiver behaviour, changed each time the four-bit phase counter wraps
    typedef enum logic [1:0] {
        RX_OPEN,      // always ready
        RX_COIN,      // ready at random
        RX_PATTERN,   // ready on a random sixteen-bit pattern
        RX_TRICKLE    // ready only when the phase counter is zero
    } t_rx_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;     // value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // character, then two padding bits
    logic        m_axis_tlast;

    t_text_char  text_q [$];
    t_value_item value_q [$];

    logic        value_taken = 1'b0;
    int          mismatches  = 0;
    int          idle_cycles = 0;

    int          burst_left  = 0;
    int          gap_left    = 0;

    t_rx_mode    rx_mode     = RX_OPEN;
    logic [15:0] rx_pattern  = 16'hFFFF;
    logic [3:0]  rx_phase    = 4'd0;

    signed_binary_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // decimal text of a two's complement value: optional minus, then digits msd first
    task automatic predict_text(input logic [31:0] value);
        logic [31:0] magnitude;
        logic [3:0]  digits [0:9];
        int          ndigits;
        t_text_char  ch;
        begin
            ndigits   = 0;
            // the most negative value negates to 2^31, which still fits unsigned
            magnitude = value[VALUE_BITS-1] ? (~value + 32'd1) : value;
            do begin
                digits[ndigits] = 4'(magnitude % 32'd10);
                magnitude       = magnitude / 32'd10;
                ndigits++;
            end while (magnitude != 0);
            ch.source = value;
            if (value[VALUE_BITS-1]) begin
                ch.code = CHAR_MINUS;
                ch.last = 1'b0;
                text_q.push_back(ch);
            end
            for (int k = ndigits - 1; k >= 0; k--) begin
                ch.code = CHAR_ZERO + CHAR_BITS'(digits[k]);
                ch.last = (k == 0);
                text_q.push_back(ch);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] source,
                                   input int got, input int want);
        begin
            $display("[%0t] mismatch on %s for value %0d: got %0d, want %0d",
                     $realtime, what, $signed(source), got, want);
            mismatches++;
        end
    endtask

    task automatic add_value(input logic [31:0] value, input bit hold);
        t_value_item item;
        begin
            item.value = value;
            item.hold  = hold;
            value_q.push_back(item);
        end
    endtask

    function automatic logic [63:0] power_of_ten(input int n);
        logic [63:0] p;
        begin
            p = 64'd1;
            for (int k = 0; k < n; k++) p = p * 64'd10;
            return p;
        end
    endfunction

    // random value: in part chosen by digit count so every text length shows up
    function automatic logic [31:0] random_value();
        logic [31:0] magnitude;
        logic [63:0] lo;
        logic [63:0] hi;
        int          n;
        begin
            magnitude = 32'd0;
            case ($urandom_range(0, 5))
                0, 1: begin
                    n  = $urandom_range(1, 10);
                    lo = (n == 1) ? 64'd0 : power_of_ten(n - 1);
                    hi = (n == 10) ? 64'd2147483647 : power_of_ten(n) - 64'd1;
                    magnitude = $urandom_range(32'(hi), 32'(lo));
                end
                2: return $urandom;
                3: begin
                    // either side of a power of ten, where the digit count changes
                    magnitude = 32'(power_of_ten($urandom_range(0, 9)))
                                + $urandom_range(0, 2) - 32'd1;
                end
                4: magnitude = $urandom_range(0, 20);
                default: begin
                    if ($urandom_range(0, 1))
                        return 32'h7FFF_FFFF - $urandom_range(0, 3);
                    else
                        return 32'h8000_0000 + $urandom_range(0, 3);
                end
            endcase
            return $urandom_range(0, 1) ? (~magnitude + 32'd1) : magnitude;
        end
    endfunction

    // sender: bursts of random length, random gaps, and a hold until all text is back
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || value_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (value_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (value_q[0].hold && text_q.size() != 0) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tdata  <= value_q.pop_front().value;
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    // now and then a long run with no gaps at all
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                             : $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // receiver: a new stall mode and pattern each time the phase counter wraps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_phase == 4'd0) begin
                rx_mode    = t_rx_mode'($urandom_range(0, 3));
                rx_pattern = 16'($urandom) | 16'h0001;
            end
            case (rx_mode)
                RX_OPEN:    m_axis_tready <= 1'b1;
                RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
                RX_PATTERN: m_axis_tready <= rx_pattern[rx_phase];
                default:    m_axis_tready <= (rx_phase == 4'd0);
            endcase
            rx_phase++;
        end
    end

    always @(posedge i_clk) begin
        value_taken <= s_axis_tvalid && s_axis_tready;
    end

    // checker and stall watchdog
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) predict_text(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (text_q.size() == 0) begin
                    report_mismatch("character with no text owed", 32'd0,
                                    int'(m_axis_tdata), -1);
                end else begin
                    want = text_q.pop_front();
                    if (m_axis_tdata[CHAR_BITS-1:0] != want.code)
                        report_mismatch("character", want.source,
                                        int'(m_axis_tdata[CHAR_BITS-1:0]), int'(want.code));
                    if (m_axis_tdata[7:CHAR_BITS] != '0)
                        report_mismatch("padding", want.source,
                                        int'(m_axis_tdata[7:CHAR_BITS]), 0);
                    if (m_axis_tlast != want.last)
                        report_mismatch("last mark", want.source,
                                        int'(m_axis_tlast), int'(want.last));
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        // directed values: zero, single digits, powers of ten and both extremes
        add_value(32'd0, 1'b0);
        add_value(32'd1, 1'b0);
        add_value(32'hFFFF_FFFF, 1'b0);
        add_value(32'd9, 1'b0);
        add_value(32'd10, 1'b0);
        add_value(-32'd9, 1'b0);
        add_value(-32'd10, 1'b0);
        add_value(32'd99, 1'b0);
        add_value(32'd100, 1'b0);
        add_value(32'h7FFF_FFFF, 1'b0);
        add_value(32'h8000_0000, 1'b0);
        add_value(32'h8000_0001, 1'b0);
        add_value(32'd999999999, 1'b0);
        add_value(32'd1000000000, 1'b0);
        add_value(-32'd999999999, 1'b0);
        add_value(-32'd1000000000, 1'b0);
        add_value(32'd1234567890, 1'b0);
        add_value(-32'd123456789, 1'b0);
        add_value(32'h5555_5555, 1'b0);
        add_value(32'hAAAA_AAAA, 1'b0);
        add_value(32'd7, 1'b1);
        for (int k = 0; k < RANDOM_ITEMS; k++)
            add_value(random_value(), (k == 140) || ($urandom_range(0, 49) == 0));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (value_q.size() != 0 || s_axis_tvalid || text_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
